// ----- hdl/mvpu_pkg.sv -----
// Package: types, operation codes and blade tables for the multivector product unit.
package mvpu_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int ELEM_COUNT      = 16;
   localparam int IDX_W           = 4;

   typedef enum logic [3:0] {
      OP_GEOMETRIC  = 4'd0,
      OP_OUTER      = 4'd1,
      OP_REGRESSIVE = 4'd2,
      OP_INNER      = 4'd3,
      OP_ADD        = 4'd4,
      OP_SUB        = 4'd5,
      OP_REVERSE    = 4'd6,
      OP_DUAL       = 4'd7,
      OP_CONJUGATE  = 4'd8,
      OP_INVOLUTE   = 4'd9,
      OP_NEGATE     = 4'd10
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [3:0]         operation;
      logic               operand_select;
      logic [3:0]         element_index;
      logic signed [31:0] element_value;
      logic               start_req;
   } req_type;

   typedef struct packed {
      logic [3:0]         result_index;
      logic signed [31:0] result_value;
      logic               result_last;
   } rsp_type;

   // Term of one blade product: sign (-1, 0, +1) and result blade.
   typedef struct packed {
      logic       nz;
      logic       neg;
      logic [3:0] k;
   } term_type;

   function automatic logic [3:0] blade_mask(input logic [3:0] i);
      logic [3:0] m;
      case (i)
         4'd0: m = 4'd0;   4'd1: m = 4'd1;   4'd2: m = 4'd2;   4'd3: m = 4'd4;
         4'd4: m = 4'd8;   4'd5: m = 4'd3;   4'd6: m = 4'd5;   4'd7: m = 4'd9;
         4'd8: m = 4'd6;   4'd9: m = 4'd10;  4'd10: m = 4'd12; 4'd11: m = 4'd7;
         4'd12: m = 4'd11; 4'd13: m = 4'd13; 4'd14: m = 4'd14; default: m = 4'd15;
      endcase
      return m;
   endfunction

   function automatic logic [3:0] mask_blade(input logic [3:0] m);
      logic [3:0] i;
      case (m)
         4'd0: i = 4'd0;   4'd1: i = 4'd1;   4'd2: i = 4'd2;   4'd3: i = 4'd5;
         4'd4: i = 4'd3;   4'd5: i = 4'd6;   4'd6: i = 4'd8;   4'd7: i = 4'd11;
         4'd8: i = 4'd4;   4'd9: i = 4'd7;   4'd10: i = 4'd9;  4'd11: i = 4'd12;
         4'd12: i = 4'd10; 4'd13: i = 4'd13; 4'd14: i = 4'd14; default: i = 4'd15;
      endcase
      return i;
   endfunction

   function automatic logic blade_flip(input logic [3:0] i);
      return (i == 4'd9) || (i == 4'd11) || (i == 4'd13);
   endfunction

   function automatic logic [2:0] grade_of(input logic [3:0] i);
      logic [3:0] m;
      m = blade_mask(i);
      return 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
   endfunction

   function automatic logic trivec_flip(input logic [3:0] i);
      return (i >= 4'd11) && (i <= 4'd14);
   endfunction

   function automatic term_type blade_mul(input logic [3:0] i, input logic [3:0] j);
      term_type   t;
      logic [3:0] m1;
      logic [3:0] m2;
      logic       par;
      logic [2:0] gr;
      m1 = blade_mask(i);
      m2 = blade_mask(j);
      t.k = mask_blade(m1 ^ m2);
      t.nz = !(m1[0] & m2[0]);
      par = 1'b0;
      for (int b = 0; b < 4; b++) begin
         if (m2[b]) begin
            gr  = grade_of(mask_blade(4'(m1 >> (b + 1))));
            par = par ^ gr[0];
         end
      end
      t.neg = par ^ blade_flip(i) ^ blade_flip(j) ^ blade_flip(t.k);
      return t;
   endfunction

   function automatic term_type term_sign(input logic [3:0] op, input logic [3:0] i,
                                          input logic [3:0] j);
      term_type   t;
      term_type   r;
      logic [2:0] gi;
      logic [2:0] gj;
      logic [2:0] d;
      gi = grade_of(i);
      gj = grade_of(j);
      d = (gi > gj) ? gi - gj : gj - gi;
      unique case (op)
         OP_GEOMETRIC: t = blade_mul(i, j);
         OP_OUTER: begin
            t = blade_mul(i, j);
            if (gi + gj != grade_of(t.k)) t.nz = 1'b0;
         end
         OP_REGRESSIVE: begin
            r = blade_mul(4'd15 - j, 4'd15 - i);
            if (grade_of(4'd15 - j) + grade_of(4'd15 - i) != grade_of(r.k)) r.nz = 1'b0;
            t.nz = r.nz;
            t.k = 4'd15 - r.k;
            t.neg = r.neg ^ trivec_flip(i) ^ trivec_flip(j) ^ trivec_flip(t.k);
         end
         default: begin
            t = blade_mul(i, j);
            if (grade_of(t.k) != d) t.nz = 1'b0;
         end
      endcase
      return t;
   endfunction

endpackage

// ----- hdl/multivector_product_unit.sv -----
// Top level: operand stores, shared multiply-accumulate unit and result sequencer.
//
// Each request transaction writes one element of operand A or B.
// A transaction with start_req set then runs the selected operation: the
// products sweep all 256 operand pairs (i, j) through one shared multiplier,
// one pair per cycle, accumulating into the result element that the pair
// targets, then the 16 results stream out in index order, one per cycle
// while the response side does not stall. A product start thus holds the
// request side through the sweep and the result stream, plus response stalls;
// add, subtract and the unary operations skip the sweep. The products are
// floored per term and each result is saturated once.
module multivector_product_unit #(
   parameter int VALUE_WIDTH = mvpu_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = mvpu_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mvpu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mvpu_pkg::rsp_type rsp_data
);
   import mvpu_pkg::*;

   localparam int PW = 2 * VALUE_WIDTH;
   localparam int AW = PW + 9;
   localparam logic signed [AW-1:0] SAT_MAX = (AW'(1) <<< (VALUE_WIDTH - 1)) - AW'(1);
   localparam logic signed [AW-1:0] SAT_MIN = -SAT_MAX - AW'(1);

   state_type                 state_ff, state_in;
   logic signed [VALUE_WIDTH-1:0] a_ff [ELEM_COUNT];
   logic signed [VALUE_WIDTH-1:0] b_ff [ELEM_COUNT];
   logic signed [AW-1:0]      acc_ff [ELEM_COUNT];
   logic [3:0]                op_ff, op_in;
   logic [7:0]                cnt_ff, cnt_in;
   logic [3:0]                emit_ff, emit_in;
   logic                      prod_vld_ff, prod_vld_in;
   logic signed [PW-1:0]      prod_ff;
   logic                      prod_neg_ff;
   logic [3:0]                prod_k_ff;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   logic                      accept;
   term_type                  term;
   logic signed [VALUE_WIDTH-1:0] av;
   logic signed [VALUE_WIDTH-1:0] bv;
   logic signed [AW-1:0]      fl;
   logic signed [AW-1:0]      ev;
   logic [2:0]                g;
   logic [VALUE_WIDTH-1:0]    sat;
   logic                      out_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_vld_ff || !rsp_stall;

   assign term = term_sign(op_ff, cnt_ff[7:4], cnt_ff[3:0]);
   assign av   = a_ff[cnt_ff[7:4]];
   assign bv   = b_ff[cnt_ff[3:0]];
   assign fl   = prod_neg_ff ? AW'((-prod_ff) >>> FRAC_BITS) : AW'(prod_ff >>> FRAC_BITS);
   assign g    = grade_of(emit_ff);

   always_comb begin
      unique case (op_ff)
         OP_ADD:       ev = AW'(a_ff[emit_ff]) + AW'(b_ff[emit_ff]);
         OP_SUB:       ev = AW'(a_ff[emit_ff]) - AW'(b_ff[emit_ff]);
         OP_REVERSE:   ev = (g == 3'd2 || g == 3'd3) ? -AW'(a_ff[emit_ff]) : AW'(a_ff[emit_ff]);
         OP_DUAL:      ev = AW'(a_ff[4'd15 - emit_ff]);
         OP_CONJUGATE: ev = (g == 3'd1 || g == 3'd2) ? -AW'(a_ff[emit_ff]) : AW'(a_ff[emit_ff]);
         OP_INVOLUTE:  ev = g[0] ? -AW'(a_ff[emit_ff]) : AW'(a_ff[emit_ff]);
         OP_NEGATE:    ev = -AW'(a_ff[emit_ff]);
         default:      ev = acc_ff[emit_ff];
      endcase
      if (ev > SAT_MAX) begin
         sat = SAT_MAX[VALUE_WIDTH-1:0];
      end else if (ev < SAT_MIN) begin
         sat = SAT_MIN[VALUE_WIDTH-1:0];
      end else begin
         sat = ev[VALUE_WIDTH-1:0];
      end
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      cnt_in      = cnt_ff;
      emit_in     = emit_ff;
      prod_vld_in = 1'b0;
      rsp_in      = rsp_ff;
      rsp_vld_in  = rsp_vld_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.start_req && req_data.operation <= OP_NEGATE) begin
               op_in   = req_data.operation;
               cnt_in  = '0;
               emit_in = '0;
               state_in = (req_data.operation <= OP_INNER) ? ST_MAC : ST_EMIT;
            end
         end
         ST_MAC: begin
            prod_vld_in = term.nz;
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff == 8'd255) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!prod_vld_ff && out_free) begin
               rsp_vld_in          = 1'b1;
               rsp_in.result_index = emit_ff;
               rsp_in.result_value = 32'(signed'(sat));
               rsp_in.result_last  = (emit_ff == 4'd15);
               emit_in             = emit_ff + 4'd1;
               if (emit_ff == 4'd15) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         prod_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         for (int n = 0; n < ELEM_COUNT; n++) begin
            a_ff[n] <= '0;
            b_ff[n] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         prod_vld_ff <= prod_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (accept) begin
            if (req_data.operand_select) begin
               b_ff[req_data.element_index] <= req_data.element_value[VALUE_WIDTH-1:0];
            end else begin
               a_ff[req_data.element_index] <= req_data.element_value[VALUE_WIDTH-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      cnt_ff      <= cnt_in;
      emit_ff     <= emit_in;
      rsp_ff      <= rsp_in;
      prod_ff     <= PW'(av) * PW'(bv);
      prod_neg_ff <= term.neg;
      prod_k_ff   <= term.k;
      if (state_ff == ST_IDLE) begin
         for (int n = 0; n < ELEM_COUNT; n++) acc_ff[n] <= '0;
      end else if (prod_vld_ff) begin
         acc_ff[prod_k_ff] <= acc_ff[prod_k_ff] + fl;
      end
   end

endmodule

// ----- hdl/mvpu_checker.sv -----
// Port checker for the multivector product unit, bound to the top level.
module mvpu_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mvpu_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mvpu_pkg::rsp_type rsp_data
);
   import mvpu_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.result_last ##1 rsp_valid
      |-> rsp_data.result_index == $past(rsp_data.result_index) + 4'd1)
      else $error("result index skipped");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.result_last == (rsp_data.result_index == 4'd15))
      else $error("last flag mismatch");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.result_last |-> req_stall)
      else $error("request taken while results pending");

endmodule

bind multivector_product_unit mvpu_checker u_mvpu_checker (.*);

// ----- dv/tb_multivector_product_unit.sv -----
// Testbench: multivector product unit, directed table plus random loads checked by a predictor.
module tb_multivector_product_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import mvpu_pkg::*;

   localparam int VW        = 32;
   localparam int FB        = 16;
   localparam int IDLE_STOP = 20000;
   localparam int N_RANDOM  = 290;
   localparam int N_DIRECT  = 18;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   multivector_product_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // Predictor state: operand stores.
   logic signed [VW-1:0] mv_a [16];
   logic signed [VW-1:0] mv_b [16];
   rsp_type              pending_elems [$];
   int                   push_total = 0;
   int                   errors = 0;
   int                   quiet_cycles = 0;
   bit                   feed_done = 1'b0;
   bit                   hold_long = 1'b0;

   function automatic int blade_grade(int idx);
      int m;
      m = blade_mask(idx[3:0]);
      return m[0] + m[1] + m[2] + m[3];
   endfunction

   // Sign of blade product i*j (0 for degenerate e0*e0); target blade in k.
   function automatic int blade_prod(int i, int j, output int k);
      int m1;
      int m2;
      int swaps;
      int s;
      m1 = blade_mask(i[3:0]);
      m2 = blade_mask(j[3:0]);
      k = mask_blade(4'(m1 ^ m2));
      if ((m1 & m2 & 1) != 0) return 0;
      swaps = 0;
      for (int b = 0; b < 4; b++)
         if (m2[b]) swaps += blade_grade(mask_blade(4'(m1 >> (b + 1))));
      s = (swaps % 2) ? -1 : 1;
      if (i == 9 || i == 11 || i == 13) s = -s;
      if (j == 9 || j == 11 || j == 13) s = -s;
      if (k == 9 || k == 11 || k == 13) s = -s;
      return s;
   endfunction

   function automatic int tri_sign(int x);
      return (x >= 11 && x <= 14) ? -1 : 1;
   endfunction

   function automatic int product_term(op_type op, int i, int j, output int k);
      int s;
      int r;
      int d;
      case (op)
         OP_GEOMETRIC: s = blade_prod(i, j, k);
         OP_OUTER: begin
            s = blade_prod(i, j, k);
            if (blade_grade(i) + blade_grade(j) != blade_grade(k)) s = 0;
         end
         OP_REGRESSIVE: begin
            s = blade_prod(15 - j, 15 - i, r);
            if (blade_grade(15 - j) + blade_grade(15 - i) != blade_grade(r)) s = 0;
            k = 15 - r;
            s = s * tri_sign(i) * tri_sign(j) * tri_sign(k);
         end
         default: begin
            s = blade_prod(i, j, k);
            d = blade_grade(i) - blade_grade(j);
            if (d < 0) d = -d;
            if (blade_grade(k) != d) s = 0;
         end
      endcase
      return s;
   endfunction

   function automatic logic signed [VW-1:0] clamp_value(logic signed [127:0] v);
      logic signed [127:0] hi;
      logic signed [127:0] lo;
      hi = (128'sd1 <<< (VW - 1)) - 1;
      lo = -(128'sd1 <<< (VW - 1));
      if (v > hi) return hi[VW-1:0];
      if (v < lo) return lo[VW-1:0];
      return v[VW-1:0];
   endfunction

   // Apply one load to the stores; on a start queue the 16 result elements.
   task automatic mv_compute(req_type t);
      logic signed [127:0] acc [16];
      logic signed [127:0] p;
      logic signed [127:0] av;
      int                  s;
      int                  k;
      int                  g;
      rsp_type             r;
      op_type              op;
      if (t.operand_select) mv_b[t.element_index] = t.element_value;
      else mv_a[t.element_index] = t.element_value;
      if (!t.start_req || t.operation > OP_NEGATE) return;
      op = op_type'(t.operation);
      for (int n = 0; n < 16; n++) acc[n] = 0;
      if (op <= OP_INNER) begin
         for (int i = 0; i < 16; i++)
            for (int j = 0; j < 16; j++) begin
               s = product_term(op, i, j, k);
               if (s != 0) begin
                  p = 128'(mv_a[i]) * 128'(mv_b[j]);
                  if (s < 0) p = -p;
                  acc[k] = acc[k] + (p >>> FB);
               end
            end
      end else begin
         for (int n = 0; n < 16; n++) begin
            av = 128'(mv_a[n]);
            g = blade_grade(n);
            case (op)
               OP_ADD:       acc[n] = av + 128'(mv_b[n]);
               OP_SUB:       acc[n] = av - 128'(mv_b[n]);
               OP_REVERSE:   acc[n] = (g == 2 || g == 3) ? -av : av;
               OP_DUAL:      acc[n] = 128'(mv_a[15 - n]);
               OP_CONJUGATE: acc[n] = (g == 1 || g == 2) ? -av : av;
               OP_INVOLUTE:  acc[n] = (g % 2) ? -av : av;
               default:      acc[n] = -av;
            endcase
         end
      end
      for (int n = 0; n < 16; n++) begin
         r.result_index = 4'(n);
         r.result_value = clamp_value(acc[n]);
         r.result_last  = (n == 15);
         pending_elems.push_back(r);
      end
      push_total++;
   endtask

   task automatic send_load(req_type t);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      mv_compute(t);
   endtask

   function automatic req_type make_load(op_type op, bit sel, int idx, int val, bit start);
      req_type t;
      t.operation      = op;
      t.operand_select = sel;
      t.element_index  = 4'(idx);
      t.element_value  = val;
      t.start_req      = start;
      return t;
   endfunction

   // Directed rows; a typed-in check value is compared with the predictor.
   req_type dir_load [N_DIRECT];
   logic signed [31:0] dir_expect [N_DIRECT];
   bit dir_has_expect [N_DIRECT];

   initial begin
      req_type t;
      int      push_mark;
      logic [3:0] rop;
      dir_load[0]  = make_load(OP_GEOMETRIC, 1'b0, 0, 0, 1'b1);
      dir_load[1]  = make_load(OP_NEGATE, 1'b0, 0, 32'h8000_0000, 1'b1);
      dir_load[2]  = make_load(OP_ADD, 1'b1, 0, 32'h7FFF_FFFF, 1'b1);
      dir_load[3]  = make_load(OP_SUB, 1'b1, 0, 32'h8000_0000, 1'b1);
      dir_load[4]  = make_load(OP_GEOMETRIC, 1'b0, 0, 32'h0001_0000, 1'b0);
      dir_load[5]  = make_load(OP_GEOMETRIC, 1'b1, 0, 32'h0002_0000, 1'b1);
      dir_load[6]  = make_load(OP_OUTER, 1'b0, 1, 32'h0003_0000, 1'b1);
      dir_load[7]  = make_load(OP_REGRESSIVE, 1'b1, 15, 32'hFFFF_0000, 1'b1);
      dir_load[8]  = make_load(OP_INNER, 1'b0, 2, 32'h7FFF_FFFF, 1'b1);
      dir_load[9]  = make_load(OP_REVERSE, 1'b0, 8, 32'h0000_0001, 1'b1);
      dir_load[10] = make_load(OP_DUAL, 1'b0, 15, 32'h8000_0000, 1'b1);
      dir_load[11] = make_load(OP_CONJUGATE, 1'b0, 11, 32'h1234_5678, 1'b1);
      dir_load[12] = make_load(OP_INVOLUTE, 1'b0, 4, 32'hFFFF_FFFF, 1'b1);
      dir_load[13] = make_load(op_type'(4'd11), 1'b0, 3, 32'h0005_0000, 1'b1);
      dir_load[14] = make_load(op_type'(4'd15), 1'b1, 3, 32'hFFFF_FFFF, 1'b1);
      dir_load[15] = make_load(OP_GEOMETRIC, 1'b1, 1, 32'h7FFF_FFFF, 1'b1);
      dir_load[16] = make_load(OP_GEOMETRIC, 1'b1, 0, 32'h8000_0000, 1'b1);
      dir_load[17] = make_load(OP_INNER, 1'b1, 14, 32'h0001_0000, 1'b1);
      foreach (dir_has_expect[n]) dir_has_expect[n] = 1'b0;
      // Element 0 of the first results: zero after reset, then the saturated maximum, minus one and zero.
      dir_has_expect[0] = 1'b1; dir_expect[0] = 32'sh0000_0000;
      dir_has_expect[1] = 1'b1; dir_expect[1] = 32'sh7FFF_FFFF;
      dir_has_expect[2] = 1'b1; dir_expect[2] = 32'shFFFF_FFFF;
      dir_has_expect[3] = 1'b1; dir_expect[3] = 32'sh0000_0000;

      for (int n = 0; n < 16; n++) begin
         mv_a[n] = '0;
         mv_b[n] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < N_DIRECT; n++) begin
         push_mark = push_total;
         send_load(dir_load[n]);
         if (dir_has_expect[n] && push_total > push_mark &&
             pending_elems[pending_elems.size() - 16].result_value !== dir_expect[n]) begin
            $display("%0t mismatch: table value exp %h act %h", $time,
                     dir_expect[n], pending_elems[pending_elems.size() - 16].result_value);
            errors++;
         end
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 40) hold_long = 1'b1;
         t.operand_select = $urandom_range(0, 1);
         t.element_index  = $urandom_range(0, 15);
         case ($urandom_range(0, 5))
            0: t.element_value = 32'h8000_0000 | $urandom_range(0, 3);
            1: t.element_value = 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: t.element_value = $urandom;
            default: t.element_value = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         endcase
         t.start_req = ($urandom_range(0, 3) == 0);
         rop = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(0, 10));
         t.operation = rop;
         send_load(t);
      end
      req_valid <= 1'b0;
      feed_done = 1'b1;
   end

   // Result side: random stalls plus one long hold to back up the block.
   initial begin
      int gap;
      wait (!reset);
      forever begin
         if (hold_long) begin
            hold_long = 1'b0;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_elems.size() == 0) begin
            $display("%0t mismatch: unexpected result exp none act %p", $time, rsp_data);
            errors++;
         end else begin
            want = pending_elems.pop_front();
            if (rsp_data.result_index !== want.result_index) begin
               $display("%0t mismatch: index exp %0d act %0d", $time,
                        want.result_index, rsp_data.result_index);
               errors++;
            end
            if (rsp_data.result_value !== want.result_value) begin
               $display("%0t mismatch: value[%0d] exp %h act %h", $time,
                        want.result_index, want.result_value, rsp_data.result_value);
               errors++;
            end
            if (rsp_data.result_last !== want.result_last) begin
               $display("%0t mismatch: last exp %b act %b", $time,
                        want.result_last, rsp_data.result_last);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_STOP) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      wait (feed_done && pending_elems.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0 && pending_elems.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
